// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Command codes, control characters, field widths and cursor control types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COMMAND_W = 2;
  localparam int CHAR_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int INDEX_W   = 11;
  // width of cell_col + cell_row * COLUMNS for the widest legal geometry
  localparam int LIN_W     = 12;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_HOME
  } cur_op_t;

  typedef struct packed {
    logic    en;
    cur_op_t op;
  } cur_cmd_t;

  typedef struct packed {
    logic last_col;
    logic last_row;
  } cur_stat_t;

endpackage

// ===== sv/tcw_char_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_char_ram: character cell store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_char_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CHAR_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CHAR_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor: cursor column, row and linear index
// Keeps the index in step with column and row, no multiplier needed.
// ----------------------------------------------------------------------------
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CW      = 7,
  parameter int RW      = 5,
  parameter int AW      = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::cur_cmd_t   cmd,
  output tcw_pkg::cur_stat_t  stat,
  output logic [CW-1:0]       col,
  output logic [RW-1:0]       row,
  output logic [AW-1:0]       idx
);
  import tcw_pkg::*;

  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [AW-1:0] idx_next;

  assign stat.last_col = (col == CW'(COLUMNS - 1));
  assign stat.last_row = (row == RW'(ROWS - 1));

  always_comb begin
    col_next = col;
    row_next = row;
    idx_next = idx;
    if (cmd.en) begin
      case (cmd.op)
        CUR_ADVANCE: begin
          if (!stat.last_col) begin
            col_next = col + CW'(1);
            idx_next = idx + AW'(1);
          end else if (!stat.last_row) begin
            col_next = '0;
            row_next = row + RW'(1);
            idx_next = idx + AW'(1);
          end else begin
            // scroll: stays on bottom row, column 0
            col_next = '0;
            idx_next = idx + AW'(1) - AW'(COLUMNS);
          end
        end
        CUR_NEWLINE: begin
          col_next = '0;
          if (stat.last_row) begin
            idx_next = idx - AW'(col);
          end else begin
            row_next = row + RW'(1);
            idx_next = idx - AW'(col) + AW'(COLUMNS);
          end
        end
        CUR_BACK: begin
          if (col != '0) begin
            col_next = col - CW'(1);
            idx_next = idx - AW'(1);
          end else if (row != '0) begin
            col_next = CW'(COLUMNS - 1);
            row_next = row - RW'(1);
            idx_next = idx - AW'(1);
          end
        end
        CUR_HOME: begin
          col_next = '0;
          row_next = '0;
          idx_next = '0;
        end
        default: begin
          col_next = col;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      idx <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      idx <= idx_next;
    end
  end

endmodule

// ===== sv/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core: character-cell text console engine
// Put, read and clear commands on a COLUMNS x ROWS store with a cursor.
// ----------------------------------------------------------------------------
// Put (no scroll), out-of-range read, unused code: strobe in the cycle after
//   start; a new word may start in the strobe cycle.
// Read in range: a registered RAM read, then the strobe; busy in between.
// Scroll: a sweep over all cells (one cell per cycle through the single RAM
//   port pair), a flush, then the strobe. Clear: a sweep, then the strobe.
// Reset: clearing pass over all cells, busy high, then idle at (0,0).
// Results cannot be stalled: strobe is high for exactly one cycle per word.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcw_pkg::COMMAND_W-1:0] command,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::COL_W-1:0]     cell_col,
  input  logic [tcw_pkg::ROW_W-1:0]     cell_row,
  output logic                          strobe,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcw_pkg::INDEX_W-1:0]   cursor_index,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_char
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  state_t state, state_next;

  // sweep pointer shared by reset fill, clear and scroll
  logic [AW-1:0] ptr, ptr_next;

  // scroll write-back stage: data read at ptr+COLUMNS lands at ptr next cycle
  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  logic          pend_copy;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  cur_cmd_t      cur_cmd;
  cur_stat_t     cur_stat;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [AW-1:0] cur_idx;

  logic              done, done_next;
  logic [CHAR_W-1:0] rd_char, rd_char_next;

  logic              accept;
  logic              ptr_last;
  logic              copy_ok;
  logic              is_newline;
  logic              is_backspace;
  logic              need_scroll;
  logic              rd_in_range;
  logic [LIN_W-1:0]  rd_lin;

  assign accept       = start && !busy;
  assign ptr_last     = (ptr == AW'(CELLS - 1));
  assign copy_ok      = (ptr < AW'(CELLS - COLUMNS));
  assign is_newline   = (char_code == CHAR_NEWLINE);
  assign is_backspace = (char_code == CHAR_BACKSPACE);
  // passing the last row: newline there, or an ordinary code in the last cell
  assign need_scroll  = (command == CMD_PUT) && !is_backspace &&
                        (is_newline ? cur_stat.last_row
                                    : (cur_stat.last_col && cur_stat.last_row));
  assign rd_in_range  = (8'(cell_col) < 8'(COLUMNS)) && (7'(cell_row) < 7'(ROWS));
  assign rd_lin       = LIN_W'(cell_col) + LIN_W'(cell_row) * LIN_W'(COLUMNS);

  tcw_char_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CW      (CW),
    .RW      (RW),
    .AW      (AW)
  ) u_cursor (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cur_cmd),
    .stat (cur_stat),
    .col  (cur_col),
    .row  (cur_row),
    .idx  (cur_idx)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (ptr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUT: begin
              if (need_scroll) state_next = ST_SCROLL;
            end
            CMD_READ: begin
              if (rd_in_range) state_next = ST_READ;
            end
            CMD_CLEAR: begin
              state_next = ST_CLEAR;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (ptr_last) state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        if (ptr_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // datapath controls
  // The FSM is the interlock: a command read is only issued from idle, after
  // every sweep write (including the scroll write-back) has landed.
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = ptr;
    ram_wdata    = '0;
    ram_raddr    = '0;
    cur_cmd.en   = 1'b0;
    cur_cmd.op   = CUR_ADVANCE;
    done_next    = 1'b0;
    rd_char_next = '0;
    ptr_next     = ptr;
    case (state)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ptr_next  = ptr_last ? '0 : ptr + AW'(1);
        done_next = (state == ST_CLEAR) && ptr_last;
      end
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUT: begin
              cur_cmd.en = 1'b1;
              done_next  = !need_scroll;
              if (is_newline) begin
                cur_cmd.op = CUR_NEWLINE;
              end else if (is_backspace) begin
                // origin only clears cell 0
                cur_cmd.op = CUR_BACK;
                ram_we     = 1'b1;
                ram_waddr  = (cur_idx == '0) ? '0 : cur_idx - AW'(1);
              end else begin
                cur_cmd.op = CUR_ADVANCE;
                ram_we     = 1'b1;
                ram_waddr  = cur_idx;
                ram_wdata  = char_code;
              end
            end
            CMD_READ: begin
              ram_raddr = AW'(rd_lin);
              done_next = !rd_in_range;
            end
            CMD_CLEAR: begin
              cur_cmd.en = 1'b1;
              cur_cmd.op = CUR_HOME;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done_next    = 1'b1;
        rd_char_next = ram_rdata;
      end
      ST_SCROLL: begin
        ram_raddr = copy_ok ? ptr + AW'(COLUMNS) : '0;
        ram_we    = pend_valid;
        ram_waddr = pend_addr;
        ram_wdata = pend_copy ? ram_rdata : '0;
        ptr_next  = ptr_last ? '0 : ptr + AW'(1);
      end
      ST_FLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = pend_addr;
        ram_wdata = pend_copy ? ram_rdata : '0;
        done_next = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      ptr        <= '0;
      done       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      done       <= done_next;
      pend_valid <= (state == ST_SCROLL);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    rd_char   <= rd_char_next;
    pend_addr <= ptr;
    pend_copy <= copy_ok;
  end

  assign busy         = (state != ST_IDLE);
  assign strobe       = done;
  assign cursor_col   = COL_W'(cur_col);
  assign cursor_row   = ROW_W'(cur_row);
  assign cursor_index = INDEX_W'(cur_idx);
  assign cell_char    = rd_char;

endmodule

// ===== sv/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker: port-level assertions for text_console_writer_core
// Checks handshake, result strobe, cursor and cell_char; bound to the core.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [tcw_pkg::COMMAND_W-1:0] command,
  input logic                          strobe,
  input logic [tcw_pkg::COL_W-1:0]     cursor_col,
  input logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  input logic [tcw_pkg::INDEX_W-1:0]   cursor_index,
  input logic [tcw_pkg::CHAR_W-1:0]    cell_char
);
  import tcw_pkg::*;

  // an accepted word either answers next cycle or keeps the core busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || strobe))
    else $error("accepted word neither answered nor went busy");

  // results only come out while idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("strobe while busy");

  // the cursor moves only on an accepted word
  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> ($stable(cursor_col) && $stable(cursor_row) &&
                           $stable(cursor_index)))
    else $error("cursor moved without a command");

  // anything answered right after a non-read word carries no character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(start && !busy && (command != CMD_READ))) |-> (cell_char == '0))
    else $error("non-read result with nonzero cell_char");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .strobe       (strobe),
  .cursor_col   (cursor_col),
  .cursor_row   (cursor_row),
  .cursor_index (cursor_index),
  .cell_char    (cell_char)
);
